// File: rtl/core/afg_pkg.sv
package afg_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_CHANNELS   = 8;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int GAIN_BITS   = GAIN_FRAC_BITS + 1;            // Q1.16
    localparam int LEN_BITS    = 32;
    localparam int CH_CNT_BITS = 4;
    localparam int CH_IDX_BITS = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int DIV_CNT_BITS = 5;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int GG_BITS     = 2 * GAIN_BITS;

    localparam logic [GAIN_BITS-1:0]    GAIN_ONE  = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic [GG_BITS-1:0]      GAIN_HALF = GG_BITS'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST  = DIV_CNT_BITS'(GAIN_BITS - 1);
    localparam logic [CH_CNT_BITS-1:0]  CH_MAX    = CH_CNT_BITS'(MAX_CHANNELS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FADE_IN   = 2'd0,
        REG_FADE_OUT  = 2'd1,
        REG_TOTAL     = 2'd2,
        REG_CHANNELS  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_IN,
        ST_DIV_OUT,
        ST_MUL_G,
        ST_MUL_SQ,
        ST_MUL_OUT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;          // capture request, apply restart
        logic init_gain;     // preset fade terms
        logic div_load;      // start a division
        logic div_sel_out;   // 0: fade-in term, 1: fade-out term
        logic div_step;      // one quotient bit
        logic mul_g;         // g = gi * go
        logic mul_sq;        // gain = g * g, rounded
        logic mul_out;       // sample * gain
        logic write_out;     // load output register, advance position
    } cmd_t;

    typedef struct packed {
        logic chan_zero;     // incoming request starts a frame
        logic fi_act;        // fade-in division needed
        logic fo_div;        // fade-out division needed
        logic div_last;      // final quotient bit this cycle
    } status_t;

endpackage

// File: rtl/core/afg_ctrl.sv
module afg_ctrl
    import afg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.chan_zero ? ST_PREP : ST_MUL_OUT;
            end
            ST_PREP:
            begin
                if (status.fi_act)
                    state_next = ST_DIV_IN;
                else if (status.fo_div)
                    state_next = ST_DIV_OUT;
                else
                    state_next = ST_MUL_G;
            end
            ST_DIV_IN:
            begin
                if (status.div_last)
                    state_next = status.fo_div ? ST_DIV_OUT : ST_MUL_G;
            end
            ST_DIV_OUT:
            begin
                if (status.div_last)
                    state_next = ST_MUL_G;
            end
            ST_MUL_G:   state_next = ST_MUL_SQ;
            ST_MUL_SQ:  state_next = ST_MUL_OUT;
            ST_MUL_OUT: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_PREP:
            begin
                cmd.init_gain = 1'b1;
                if (status.fi_act)
                    cmd.div_load = 1'b1;
                else if (status.fo_div)
                begin
                    cmd.div_load    = 1'b1;
                    cmd.div_sel_out = 1'b1;
                end
            end
            ST_DIV_IN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last && status.fo_div)
                begin
                    cmd.div_load    = 1'b1;
                    cmd.div_sel_out = 1'b1;
                end
            end
            ST_DIV_OUT: cmd.div_step = 1'b1;
            ST_MUL_G:   cmd.mul_g    = 1'b1;
            ST_MUL_SQ:  cmd.mul_sq   = 1'b1;
            ST_MUL_OUT: cmd.mul_out  = 1'b1;
            ST_WRITE:   cmd.write_out = !out_valid_reg || !out_stall;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/afg_datapath.sv
module afg_datapath
    import afg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LEN_BITS-1:0]     cfg_data,
    input  logic [SAMPLE_BITS-1:0]  sample_in,
    input  logic                    restart,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic [SAMPLE_BITS-1:0]  faded_sample
);

    // configuration
    logic [LEN_BITS-1:0]    fade_in_reg, fade_out_reg, total_reg;
    logic [CH_CNT_BITS-1:0] chan_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_in_reg  <= '0;
            fade_out_reg <= '0;
            total_reg    <= '0;
            chan_cnt_reg <= CH_CNT_BITS'(2);
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FADE_IN:  fade_in_reg  <= cfg_data;
                REG_FADE_OUT: fade_out_reg <= cfg_data;
                REG_TOTAL:    total_reg    <= cfg_data;
                REG_CHANNELS: chan_cnt_reg <= cfg_data[CH_CNT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // frame tracking
    logic [LEN_BITS-1:0]    pos_reg, pos_next;
    logic [CH_IDX_BITS-1:0] ch_reg, ch_next;
    logic [CH_CNT_BITS-1:0] chans_eff, ch_plus;

    always_comb
    begin
        if (chan_cnt_reg == '0)
            chans_eff = CH_CNT_BITS'(1);
        else if (chan_cnt_reg > CH_MAX)
            chans_eff = CH_MAX;
        else
            chans_eff = chan_cnt_reg;
        ch_plus  = {1'b0, ch_reg} + CH_CNT_BITS'(1);
        pos_next = pos_reg;
        ch_next  = ch_reg;
        if (cmd.load && restart)
        begin
            pos_next = '0;
            ch_next  = '0;
        end
        else if (cmd.write_out)
        begin
            if (ch_plus >= chans_eff)
            begin
                ch_next = '0;
                if (pos_reg != '1)
                    pos_next = pos_reg + LEN_BITS'(1);
            end
            else
                ch_next = ch_plus[CH_IDX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ch_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            ch_reg  <= ch_next;
        end
    end

    // fade window decode on the stored position
    logic fo_window, past_end;

    assign fo_window = (fade_out_reg != '0) && (total_reg != '0) &&
                       (({1'b0, pos_reg} + {1'b0, fade_out_reg}) >= {1'b0, total_reg});
    assign past_end  = pos_reg >= total_reg;

    assign status.chan_zero = restart || (ch_reg == '0);
    assign status.fi_act    = (fade_in_reg != '0) && (pos_reg < fade_in_reg);
    assign status.fo_div    = fo_window && !past_end;

    // restoring divider, (x << 16) / d, 17 quotient bits
    logic [LEN_BITS-1:0]     rem_reg, dvs_reg;
    logic [GAIN_BITS-1:0]    quo_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    nbit_reg, sel_reg;
    logic [LEN_BITS-1:0]     div_x;
    logic [LEN_BITS:0]       trial, diff;
    logic                    qbit;
    logic [GAIN_BITS-1:0]    quo_next;

    assign div_x    = cmd.div_sel_out ? (total_reg - pos_reg) : pos_reg;
    assign trial    = {rem_reg, nbit_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign qbit     = !diff[LEN_BITS];
    assign quo_next = {quo_reg[GAIN_BITS-2:0], qbit};
    assign status.div_last = cnt_reg == DIV_LAST;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= {1'b0, div_x[LEN_BITS-1:1]};
            nbit_reg <= div_x[0];
            dvs_reg  <= cmd.div_sel_out ? fade_out_reg : fade_in_reg;
            sel_reg  <= cmd.div_sel_out;
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= qbit ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
            nbit_reg <= 1'b0;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_reg + DIV_CNT_BITS'(1);
        end
    end

    // gain terms and multiplies
    logic [GAIN_BITS-1:0]   gi_reg, go_reg, g_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [GG_BITS-1:0]     gg_prod, sq_prod;
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next, rnd;

    assign gg_prod   = gi_reg * go_reg;
    assign sq_prod   = (g_reg * g_reg) + GAIN_HALF;
    assign prod_next = $signed(samp_reg) * $signed({1'b0, gain_reg});
    assign rnd       = (prod_reg + PROD_BITS'(GAIN_HALF)) >>> GAIN_FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_ONE;
        else if (cmd.mul_sq)
            gain_reg <= sq_prod[GAIN_FRAC_BITS +: GAIN_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            samp_reg <= sample_in;
        if (cmd.init_gain)
        begin
            gi_reg <= GAIN_ONE;
            go_reg <= (fo_window && past_end) ? '0 : GAIN_ONE;
        end
        if (cmd.div_step && status.div_last)
        begin
            if (sel_reg)
                go_reg <= quo_next;
            else
                gi_reg <= quo_next;
        end
        if (cmd.mul_g)
            g_reg <= gg_prod[GAIN_FRAC_BITS +: GAIN_BITS];
        if (cmd.mul_out)
            prod_reg <= prod_next;
        if (cmd.write_out)
            faded_sample <= rnd[SAMPLE_BITS-1:0];
    end

endmodule

// File: rtl/core/audio_fade_in_out_gain.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  sample_in[23:0] signed, restart
// out       out_valid/ out_stall faded_sample[23:0] signed
// cfg       cfg_valid/ cfg_ready cfg_index[1:0], cfg_data[31:0]
//
// A frame-opening request runs accept, setup, two 17-step divisions on one
// shared restoring divider (each skipped when not needed), three multiply
// steps and write-back. Other requests run accept, output multiply, write-back.
// One request is in work at a time; the next is taken while the result
// waits in the output register, and a stalled result holds write-back.
// Async active-low reset restores gain 1.0, position 0, two channels.
module audio_fade_in_out_gain
    import afg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_BITS-1:0]  sample_in,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_BITS-1:0]  faded_sample,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LEN_BITS-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    // config writes land directly in the config registers, no backpressure
    assign cfg_ready = 1'b1;

    // sequencing: accept, gain setup, divisions, multiplies, write-back
    afg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // registers, frame tracking, divider, multipliers, output register
    afg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_in    (sample_in),
        .restart      (restart),
        .cmd          (cmd),
        .status       (status),
        .faded_sample (faded_sample)
    );

endmodule

// File: rtl/core/afg_checker.sv
module afg_checker
    import afg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [SAMPLE_BITS-1:0]  faded_sample,
    input logic                    cfg_valid,
    input logic                    cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(faded_sample))
        else $error("stalled result changed");

    // one request in work at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // a new result only comes out of a request in work
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without request");

    // config port never backpressures
    a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind audio_fade_in_out_gain afg_checker u_chk (.*);
